// ===== hdl/ldorb_pkg.sv =====
// Shared types, codes and constants for the LDO rail register block.
`timescale 1ns / 1ps
`default_nettype none
package ldorb_pkg;

  typedef enum logic [1:0] {
    OP_ENABLE  = 2'd0,
    OP_DISABLE = 2'd1,
    OP_SET     = 2'd2,
    OP_GET     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         opcode;
    logic [2:0]  channel;
    logic [15:0] millivolts;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [12:0] millivolts_read;
    logic [4:0]  enable_mask;
  } out_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic div;
    logic exec;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div;
  } sts_t;

  localparam int unsigned NUM_RAILS = 5;

  localparam logic [2:0] CH_FIRST = 3'd2;
  localparam logic [2:0] CH_LAST  = 3'd6;
  localparam logic [2:0] CH_LIN100 = 3'd2;
  localparam logic [2:0] CH_LIN50  = 3'd3;
  localparam logic [2:0] CH_MENU   = 3'd4;

  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Scale offsets in millivolts.
  localparam logic [15:0] OFF_CH2       = 16'd1500;
  localparam logic [15:0] OFF_HIGH      = 16'd2650;
  localparam logic [15:0] OFF_LOW       = 16'd1700;
  localparam logic [15:0] SPLIT_LOW_MAX = 16'd2450;

  // A wrapped 32-bit difference 2^32-d divided by C has quotient K - (d + C-1-R)/C,
  // where 2^32 = K*C + R. C-1-R is 3 for both C=100 and C=50.
  localparam logic [15:0] WRAP_ADJ = 16'd3;
  localparam logic [4:0] BASE_CH2_WRAP = 5'd8;   // K mod 32, C=100
  localparam logic [4:0] BASE_CH3_WRAP = 5'd1;   // K mod 16, C=50
  localparam logic [4:0] BASE_LOW_WRAP = 5'd17;  // K mod 32, C=50
  localparam logic [4:0] BASE_HIGH     = 5'd16;

  // x/25 = (x*RECIP25) >> RECIP_SHIFT, exact for any 15-bit x.
  localparam logic [14:0] RECIP25     = 15'd20972;
  localparam int unsigned RECIP_SHIFT = 19;

  localparam logic [7:0] KEEP_MENU   = 8'h5D;
  localparam logic [7:0] MENU_ENABLE = 8'h02;
  localparam logic [7:0] DISABLE_SET = 8'hA2;
  localparam logic [7:0] KEEP_CH2    = 8'hE0;
  localparam logic [7:0] KEEP_CH3    = 8'hF0;

  typedef struct packed {
    logic       ok;
    logic [7:0] sel;
  } menu_t;

  function automatic menu_t menu_code(input logic [15:0] mv);
    menu_t m;
    m.ok = 1'b1;
    unique case (mv)
      16'd2700: m.sel = 8'h02;
      16'd2800: m.sel = 8'h20;
      16'd2900: m.sel = 8'h22;
      16'd3000: m.sel = 8'h80;
      16'd3200: m.sel = 8'h82;
      16'd3300: m.sel = 8'hA0;
      default: begin
        m.ok  = 1'b0;
        m.sel = 8'h00;
      end
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ldorb_ctrl.sv =====
// Command sequencer: accept, optional divide step, execute, present result.
`timescale 1ns / 1ps
`default_nettype none
module ldorb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          out_stall,
  input  wire ldorb_pkg::sts_t sts,
  output ldorb_pkg::cmd_t    cmd,
  output logic               in_stall,
  output logic               out_valid
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.need_div ? ST_DIV : ST_EXEC;
        end
      end
      ST_DIV:  state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);
  assign cmd.load  = (state_r == ST_IDLE) && in_valid;
  assign cmd.div   = (state_r == ST_DIV);
  assign cmd.exec  = (state_r == ST_EXEC);

endmodule
`default_nettype wire

// ===== hdl/ldorb_datapath.sv =====
// Rail registers, voltage encode/decode and result register.
`timescale 1ns / 1ps
`default_nettype none
module ldorb_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire ldorb_pkg::cmd_t cmd,
  input  wire ldorb_pkg::in_t  in_data,
  output ldorb_pkg::sts_t      sts,
  output ldorb_pkg::out_t      out_data
);

  ldorb_pkg::op_t op_r;
  logic [2:0]  ch_r;
  logic [15:0] mv_r;
  logic [29:0] prod_r;
  logic [4:0]  base_r;
  logic        sub_r;
  logic        gap_r;
  logic [4:0]  en_r, en_nxt;
  logic [7:0]  vb_r [ldorb_pkg::NUM_RAILS];
  ldorb_pkg::out_t out_r;

  // Divide step inputs.
  logic [15:0] num;
  logic [4:0]  base;
  logic        sub;
  logic        gap;
  logic        half;
  logic [14:0] x;
  logic [29:0] prod;

  // Execute step.
  logic [4:0]  q5;
  logic [4:0]  code5;
  logic [2:0]  idx;
  logic [4:0]  bit_sel;
  logic [7:0]  vb_cur;
  logic        ch_ok;
  logic        vb_wr;
  logic [7:0]  vb_val;
  logic        status;
  logic [12:0] mvr;
  ldorb_pkg::menu_t menu;

  assign sts.need_div = (in_data.opcode == ldorb_pkg::OP_SET) &&
                        (in_data.channel >= ldorb_pkg::CH_FIRST) &&
                        (in_data.channel <= ldorb_pkg::CH_LAST) &&
                        (in_data.channel != ldorb_pkg::CH_MENU);

  // Numerator and code base; wrapped differences are counted down from K.
  always_comb begin
    num  = '0;
    base = '0;
    sub  = 1'b0;
    gap  = 1'b0;
    half = 1'b1;
    priority if (ch_r == ldorb_pkg::CH_LIN100) begin
      half = 1'b0;
      if (mv_r >= ldorb_pkg::OFF_CH2) begin
        num = mv_r - ldorb_pkg::OFF_CH2;
      end else begin
        num  = ldorb_pkg::OFF_CH2 - mv_r + ldorb_pkg::WRAP_ADJ;
        sub  = 1'b1;
        base = ldorb_pkg::BASE_CH2_WRAP;
      end
    end else if (ch_r == ldorb_pkg::CH_LIN50) begin
      if (mv_r >= ldorb_pkg::OFF_HIGH) begin
        num = mv_r - ldorb_pkg::OFF_HIGH;
      end else begin
        num  = ldorb_pkg::OFF_HIGH - mv_r + ldorb_pkg::WRAP_ADJ;
        sub  = 1'b1;
        base = ldorb_pkg::BASE_CH3_WRAP;
      end
    end else begin
      if (mv_r <= ldorb_pkg::SPLIT_LOW_MAX) begin
        if (mv_r >= ldorb_pkg::OFF_LOW) begin
          num = mv_r - ldorb_pkg::OFF_LOW;
        end else begin
          num  = ldorb_pkg::OFF_LOW - mv_r + ldorb_pkg::WRAP_ADJ;
          sub  = 1'b1;
          base = ldorb_pkg::BASE_LOW_WRAP;
        end
      end else if (mv_r >= ldorb_pkg::OFF_HIGH) begin
        num  = mv_r - ldorb_pkg::OFF_HIGH;
        base = ldorb_pkg::BASE_HIGH;
      end else begin
        gap = 1'b1;
      end
    end
  end

  // Divide by 50 or 100 as a shift followed by division by 25.
  assign x    = half ? num[15:1] : num[15:2];
  assign prod = 30'(x) * 30'(ldorb_pkg::RECIP25);

  assign q5    = prod_r[ldorb_pkg::RECIP_SHIFT +: 5];
  assign code5 = gap_r ? 5'd0 : (sub_r ? (base_r - q5) : (base_r + q5));

  assign ch_ok   = (ch_r >= ldorb_pkg::CH_FIRST) && (ch_r <= ldorb_pkg::CH_LAST);
  assign idx     = ch_r - ldorb_pkg::CH_FIRST;
  assign bit_sel = 5'b00001 << idx;
  assign vb_cur  = vb_r[idx];
  assign menu    = ldorb_pkg::menu_code(mv_r);

  // The channel 4 guard bit is set and then cleared within one enable, so it
  // never holds a value past the step and needs no storage.
  always_comb begin
    en_nxt = en_r;
    vb_wr  = 1'b0;
    vb_val = vb_cur;
    status = ldorb_pkg::STATUS_DONE;
    mvr    = '0;
    if (!ch_ok) begin
      status = ldorb_pkg::STATUS_REJECT;
    end else begin
      unique case (op_r)
        ldorb_pkg::OP_ENABLE: begin
          en_nxt = en_r | bit_sel;
          if (ch_r == ldorb_pkg::CH_MENU) begin
            vb_wr  = 1'b1;
            vb_val = (vb_cur & ldorb_pkg::KEEP_MENU) | ldorb_pkg::MENU_ENABLE;
          end
        end
        ldorb_pkg::OP_DISABLE: begin
          en_nxt = en_r & ~bit_sel;
          if (ch_r == ldorb_pkg::CH_MENU) begin
            vb_wr  = 1'b1;
            vb_val = vb_cur | ldorb_pkg::DISABLE_SET;
          end
        end
        ldorb_pkg::OP_SET: begin
          unique case (ch_r)
            ldorb_pkg::CH_LIN100: begin
              vb_wr  = 1'b1;
              vb_val = (vb_cur & ldorb_pkg::KEEP_CH2) | {3'b000, code5};
            end
            ldorb_pkg::CH_LIN50: begin
              vb_wr  = 1'b1;
              vb_val = (vb_cur & ldorb_pkg::KEEP_CH3) | {4'b0000, code5[3:0]};
            end
            ldorb_pkg::CH_MENU: begin
              if (menu.ok) begin
                vb_wr  = 1'b1;
                vb_val = (vb_cur & ldorb_pkg::KEEP_MENU) | menu.sel;
              end else begin
                status = ldorb_pkg::STATUS_REJECT;
              end
            end
            default: begin
              vb_wr  = 1'b1;
              vb_val = (vb_cur & ldorb_pkg::KEEP_CH2) | {3'b000, code5};
            end
          endcase
        end
        ldorb_pkg::OP_GET: begin
          unique case (ch_r)
            ldorb_pkg::CH_LIN100: mvr = 13'd1500 + 13'(vb_cur[4:0]) * 13'd100;
            ldorb_pkg::CH_LIN50:  mvr = 13'd2650 + 13'(vb_cur[3:0]) * 13'd50;
            ldorb_pkg::CH_MENU:   status = ldorb_pkg::STATUS_REJECT;
            default: begin
              if (vb_cur[4]) begin
                mvr = 13'd2650 + 13'(vb_cur[3:0]) * 13'd50;
              end else begin
                mvr = 13'd1700 + 13'(vb_cur[3:0]) * 13'd50;
              end
            end
          endcase
        end
        default: status = ldorb_pkg::STATUS_REJECT;
      endcase
    end
  end

  // Command capture, divide pipeline and result register: payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data.opcode;
      ch_r <= in_data.channel;
      mv_r <= in_data.millivolts;
    end
    if (cmd.div) begin
      prod_r <= prod;
      base_r <= base;
      sub_r  <= sub;
      gap_r  <= gap;
    end
    if (cmd.exec) begin
      out_r.status          <= status;
      out_r.millivolts_read <= mvr;
      out_r.enable_mask     <= en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
      for (int k = 0; k < ldorb_pkg::NUM_RAILS; k++) begin
        vb_r[k] <= '0;
      end
    end else if (cmd.exec) begin
      en_r <= en_nxt;
      if (vb_wr) begin
        vb_r[idx] <= vb_val;
      end
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== hdl/ldo_rail_register_block.sv =====
// Top level of the LDO rail register block: controller plus datapath.
//
//   channel | handshake           | beat
//   --------+---------------------+------------------------------------
//   in      | in_valid / in_stall | opcode, channel, millivolts
//   out     | out_valid/out_stall | status, millivolts_read, enable_mask
//
// One command at a time. A set on channels 2, 3, 5 or 6 adds a divide step
// (the reciprocal multiply) between accept and execute; other commands go
// straight to execute. The result register is held while out_stall is high and
// in_stall stays high until the result beat is taken.
// Synchronous reset clears all rail registers and the enable bits.
`timescale 1ns / 1ps
`default_nettype none
module ldo_rail_register_block (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire ldorb_pkg::in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output ldorb_pkg::out_t     out_data
);

  ldorb_pkg::cmd_t cmd;
  ldorb_pkg::sts_t sts;

  ldorb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  ldorb_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while a result beat is pending");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result shown in the cycle after accept");

  a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sts.need_div) |=> ##1 out_valid)
    else $error("command without divide step did not finish in two cycles");

  a_div_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && sts.need_div) |=> ##2 out_valid)
    else $error("set command did not finish in three cycles");
`endif

endmodule
`default_nettype wire
